/* src/tpqe_pkg.sv */
// shared types and constants for the thick polyline quad expander
package tpqe_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 8;

   localparam logic [15:0] LINE_WIDTH_RESET = 16'd1024;

   // configuration register indexes
   localparam logic [1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_CLOSED_LOOP = 2'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PICK,
      S_NORM,
      S_SQY,
      S_SQRT,
      S_DIVX,
      S_DIVY,
      S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_LOAD1,
      CMD_LOAD2,
      CMD_NORM,
      CMD_SQX,
      CMD_SQY,
      CMD_SQRT,
      CMD_DIVX_INIT,
      CMD_DIV,
      CMD_DIVY_INIT,
      CMD_DIV_FIN,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic seg1_pend;
      logic seg2_pend;
      logic norm_done;
      logic sqrt_done;
      logic div_done;
      logic emit_end;
      logic rsp_free;
   } status_type;

endpackage

/* src/tpqe_ctrl.sv */
// sequencing state machine for the quad expander
module tpqe_ctrl
   import tpqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_PICK;
         S_PICK: begin
            if (status.seg1_pend || status.seg2_pend) state_in = S_NORM;
            else state_in = S_IDLE;
         end
         S_NORM: if (status.norm_done) state_in = S_SQY;
         S_SQY:  state_in = S_SQRT;
         S_SQRT: if (status.sqrt_done) state_in = S_DIVX;
         S_DIVX: if (status.div_done) state_in = S_DIVY;
         S_DIVY: if (status.div_done) state_in = S_EMIT;
         S_EMIT: if (status.rsp_free && status.emit_end) state_in = S_PICK;
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = CMD_ACCEPT;
         end
         S_PICK: begin
            if (status.seg1_pend) cmd = CMD_LOAD1;
            else if (status.seg2_pend) cmd = CMD_LOAD2;
         end
         S_NORM: cmd = status.norm_done ? CMD_SQX : CMD_NORM;
         S_SQY:  cmd = CMD_SQY;
         S_SQRT: cmd = status.sqrt_done ? CMD_DIVX_INIT : CMD_SQRT;
         S_DIVX: cmd = status.div_done ? CMD_DIVY_INIT : CMD_DIV;
         S_DIVY: cmd = status.div_done ? CMD_DIV_FIN : CMD_DIV;
         S_EMIT: if (status.rsp_free) cmd = CMD_EMIT;
         default: cmd = CMD_NONE;
      endcase
   end

endmodule

/* src/tpqe_datapath.sv */
// point store, normalize, square root, divider and vertex output datapath
module tpqe_datapath
   import tpqe_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_last_point,
   input  logic                         csr_valid,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_vertex_x,
   output logic signed [COORD_BITS-1:0] rsp_vertex_y,
   output logic                         rsp_last_of_run
);

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int MW   = (C + 1 > 31) ? C + 1 : 31;
   localparam int S1   = (F >= 9) ? F - 9 : 0;
   localparam int S2   = (F < 9) ? 9 - F : 0;
   localparam int NUMW = 47 + S1;
   localparam int DENW = 32 + S2;
   localparam int NW1  = ((NUMW > DENW) ? NUMW : DENW) + 1;
   localparam int CW   = $clog2(NW1 + 1);
   localparam int OW   = F + 8;
   localparam int OSW  = OW + 1;
   localparam int VW   = ((C > OSW) ? C : OSW) + 2;

   localparam logic signed [VW-1:0] CMAX_V = {{(VW-C+1){1'b0}}, {(C-1){1'b1}}};
   localparam logic signed [VW-1:0] CMIN_V = {{(VW-C+1){1'b1}}, {(C-1){1'b0}}};

   // configuration and control registers
   logic [15:0]  lw_ff, lw_in;
   logic         cl_ff, cl_in;
   logic [1:0]   seen_ff, seen_in;
   logic         seg1_ff, seg1_in, seg2_ff, seg2_in, is2_ff, is2_in;
   logic         rv_ff, rv_in;
   logic [2:0]   idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // payload registers
   logic signed [C-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [C-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [C-1:0] p0x_ff, p0x_in, p0y_ff, p0y_in, p1x_ff, p1x_in, p1y_ff, p1y_in;
   logic [MW-1:0]       ax_ff, ax_in, ay_ff, ay_in;
   logic                negx_ff, negx_in, negy_ff, negy_in;
   logic [61:0]         sq_ff, sq_in;
   logic [63:0]         v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [DENW-1:0]     den_ff, den_in, rem_ff, rem_in;
   logic [NW1-1:0]      numr_ff, numr_in;
   logic signed [OSW-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic signed [C-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic                vl_ff, vl_in;

   // combinational helpers
   logic signed [C-1:0] lx0, ly0, lx1, ly1;
   logic signed [C:0]   dx, dy;
   logic [MW-1:0]       m;
   logic [30:0]         ax31, ay31;
   logic [63:0]         trial_sq;
   logic [DENW-1:0]     den_new;
   logic [46:0]         prod;
   logic [DENW:0]       trial;
   logic                ge;
   logic [OW-1:0]       q;
   logic signed [OSW-1:0] q_signed;
   logic signed [VW-1:0] x0e, y0e, x1e, y1e, oxe, oye;
   logic signed [VW-1:0] a1x, a1y, a0x, a0y, b0x, b0y, b1x, b1y, selx, sely;

   function automatic logic signed [C-1:0] sat_coord(input logic signed [VW-1:0] val);
      logic signed [VW-1:0] t;
      t = val;
      if (t > CMAX_V) t = CMAX_V;
      else if (t < CMIN_V) t = CMIN_V;
      return t[C-1:0];
   endfunction

   // segment source selection and difference
   always_comb begin
      lx0 = (cmd == CMD_LOAD2) ? prev_x_ff : p0x_ff;
      ly0 = (cmd == CMD_LOAD2) ? prev_y_ff : p0y_ff;
      lx1 = (cmd == CMD_LOAD2) ? first_x_ff : p1x_ff;
      ly1 = (cmd == CMD_LOAD2) ? first_y_ff : p1y_ff;
      dx  = (C+1)'(lx1) - (C+1)'(lx0);
      dy  = (C+1)'(ly1) - (C+1)'(ly0);
   end

   assign m        = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign ax31     = ax_ff[30:0];
   assign ay31     = ay_ff[30:0];
   assign trial_sq = res_ff + bit_ff;
   assign den_new  = DENW'(res_ff[31:0]) << S2;
   assign prod     = (cmd == CMD_DIVX_INIT) ? ax31 * lw_ff : ay31 * lw_ff;
   assign trial    = {rem_ff, numr_ff[NW1-1]};
   assign ge       = trial >= {1'b0, den_ff};
   assign q        = numr_ff[OW-1:0];

   // vertex corners
   always_comb begin
      x0e = VW'(p0x_ff);
      y0e = VW'(p0y_ff);
      x1e = VW'(p1x_ff);
      y1e = VW'(p1y_ff);
      oxe = VW'(ox_ff);
      oye = VW'(oy_ff);
      a1x = x0e - oxe + oye;  a1y = y0e - oye - oxe;
      a0x = x0e - oxe - oye;  a0y = y0e - oye + oxe;
      b0x = x1e + oxe - oye;  b0y = y1e + oye + oxe;
      b1x = x1e + oxe + oye;  b1y = y1e + oye - oxe;
      unique case (idx_ff)
         3'd0, 3'd3: begin selx = a1x; sely = a1y; end
         3'd1:       begin selx = a0x; sely = a0y; end
         3'd2, 3'd4: begin selx = b0x; sely = b0y; end
         default:    begin selx = b1x; sely = b1y; end
      endcase
   end

   // next values
   always_comb begin
      lw_in = lw_ff;  cl_in = cl_ff;  seen_in = seen_ff;
      seg1_in = seg1_ff;  seg2_in = seg2_ff;  is2_in = is2_ff;
      idx_in = idx_ff;  cnt_in = cnt_ff;
      first_x_in = first_x_ff;  first_y_in = first_y_ff;
      prev_x_in = prev_x_ff;  prev_y_in = prev_y_ff;
      p0x_in = p0x_ff;  p0y_in = p0y_ff;  p1x_in = p1x_ff;  p1y_in = p1y_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  negx_in = negx_ff;  negy_in = negy_ff;
      sq_in = sq_ff;  v_in = v_ff;  res_in = res_ff;  bit_in = bit_ff;
      den_in = den_ff;  rem_in = rem_ff;  numr_in = numr_ff;
      ox_in = ox_ff;  oy_in = oy_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  vl_in = vl_ff;
      q_signed = OSW'(q);
      rv_in = rv_ff && !rsp_ready;

      // register writes
      if (csr_valid) begin
         if (csr_index == CSR_LINE_WIDTH) lw_in = csr_wdata;
         else if (csr_index == CSR_CLOSED_LOOP) cl_in = csr_wdata[0];
      end

      unique case (cmd)
         CMD_ACCEPT: begin
            if (seen_ff == 2'd0) begin
               first_x_in = req_point_x;
               first_y_in = req_point_y;
            end
            p0x_in = prev_x_ff;  p0y_in = prev_y_ff;
            p1x_in = req_point_x;  p1y_in = req_point_y;
            prev_x_in = req_point_x;  prev_y_in = req_point_y;
            seg1_in = (seen_ff != 2'd0) &&
                      ((req_point_x != prev_x_ff) || (req_point_y != prev_y_ff));
            seg2_in = req_last_point && cl_ff && (seen_ff != 2'd0) &&
                      ((req_point_x != first_x_ff) || (req_point_y != first_y_ff));
            if (req_last_point) seen_in = 2'd0;
            else if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
         end
         CMD_LOAD1, CMD_LOAD2: begin
            p0x_in = lx0;  p0y_in = ly0;  p1x_in = lx1;  p1y_in = ly1;
            negx_in = dx[C];
            negy_in = dy[C];
            ax_in = MW'(dx[C] ? $unsigned(-dx) : $unsigned(dx));
            ay_in = MW'(dy[C] ? $unsigned(-dy) : $unsigned(dy));
            is2_in = (cmd == CMD_LOAD2);
            if (cmd == CMD_LOAD1) seg1_in = 1'b0;
            else seg2_in = 1'b0;
         end
         CMD_NORM: begin
            if (m < (MW'(1) << 30)) begin
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
            end else begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end
         end
         CMD_SQX: sq_in = ax31 * ax31;
         CMD_SQY: begin
            v_in   = 64'(sq_ff) + 64'(ay31 * ay31);
            res_in = 64'd0;
            bit_in = 64'd1 << 62;
         end
         CMD_SQRT: begin
            if (v_ff >= trial_sq) begin
               v_in   = v_ff - trial_sq;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         CMD_DIVX_INIT, CMD_DIVY_INIT: begin
            if (cmd == CMD_DIVY_INIT) ox_in = negx_ff ? -q_signed : q_signed;
            den_in  = den_new;
            numr_in = (NW1'(prod) << S1) + NW1'(den_new >> 1);
            rem_in  = '0;
            cnt_in  = CW'(NW1);
         end
         CMD_DIV: begin
            rem_in  = ge ? DENW'(trial - {1'b0, den_ff}) : trial[DENW-1:0];
            numr_in = {numr_ff[NW1-2:0], ge};
            cnt_in  = cnt_ff - CW'(1);
         end
         CMD_DIV_FIN: begin
            oy_in  = negy_ff ? -q_signed : q_signed;
            idx_in = 3'd0;
         end
         CMD_EMIT: begin
            vx_in  = sat_coord(selx);
            vy_in  = sat_coord(sely);
            vl_in  = (idx_ff == 3'd5) && (is2_ff || !seg2_ff);
            rv_in  = 1'b1;
            idx_in = idx_ff + 3'd1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff   <= LINE_WIDTH_RESET;
         cl_ff   <= 1'b0;
         seen_ff <= 2'd0;
         seg1_ff <= 1'b0;
         seg2_ff <= 1'b0;
         is2_ff  <= 1'b0;
         rv_ff   <= 1'b0;
         idx_ff  <= 3'd0;
         cnt_ff  <= '0;
      end else begin
         lw_ff   <= lw_in;
         cl_ff   <= cl_in;
         seen_ff <= seen_in;
         seg1_ff <= seg1_in;
         seg2_ff <= seg2_in;
         is2_ff  <= is2_in;
         rv_ff   <= rv_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;  first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;   prev_y_ff  <= prev_y_in;
      p0x_ff <= p0x_in;  p0y_ff <= p0y_in;  p1x_ff <= p1x_in;  p1y_ff <= p1y_in;
      ax_ff <= ax_in;  ay_ff <= ay_in;  negx_ff <= negx_in;  negy_ff <= negy_in;
      sq_ff <= sq_in;  v_ff <= v_in;  res_ff <= res_in;  bit_ff <= bit_in;
      den_ff <= den_in;  rem_ff <= rem_in;  numr_ff <= numr_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;
      vx_ff <= vx_in;  vy_ff <= vy_in;  vl_ff <= vl_in;
   end

   // status back to the controller
   always_comb begin
      status.seg1_pend = seg1_ff;
      status.seg2_pend = seg2_ff;
      status.norm_done = (64'(m) >= (64'd1 << 30)) && (64'(m) < (64'd1 << 31));
      status.sqrt_done = (bit_ff == 64'd0);
      status.div_done  = (cnt_ff == '0);
      status.emit_end  = (idx_ff == 3'd5);
      status.rsp_free  = !rv_ff || rsp_ready;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_vertex_x    = vx_ff;
   assign rsp_vertex_y    = vy_ff;
   assign rsp_last_of_run = vl_ff;

endmodule

/* src/thick_polyline_quad_expander_core.sv */
// top level of the thick polyline quad expander
//
// Points enter on the req_ channel (valid/ready), one per transaction, with
// req_last_point set on the final point of a polyline. Each segment of the
// polyline comes out on the rsp_ channel as six vertices a1,a0,b0,a1,b0,b1
// of a square-capped quad; rsp_last_of_run marks the final vertex that one
// point causes. Zero-length segments produce nothing.
// The csr_ channel writes line_width (index 0) and closed_loop (index 1);
// it is always ready and should only be used while the block is idle.
// Per segment the sequencer loads it, makes 7 to 30 normalize shifts, squares
// x and then y, runs 32 square-root steps, loads the divider, runs two
// restoring divisions of NW1 steps, each after its own load, and then emits
// the six vertices. Points are taken one at a time: a new point is accepted
// only once every segment that the last one formed is through.
// Reset (synchronous, active high) restores line_width 4.0, open mode and
// starts a new polyline. A stalled rsp_ready holds the current vertex and
// the sequencer waits; no vertex is lost.
module thick_polyline_quad_expander_core
   import tpqe_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_last_point,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_vertex_x,
   output logic signed [COORD_BITS-1:0] rsp_vertex_y,
   output logic                         rsp_last_of_run,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   tpqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   tpqe_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_last_point  (req_last_point),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* tb/tb.sv */
// self-checking testbench for the thick polyline quad expander core
`timescale 1ns / 100ps

module tb;
   import tpqe_pkg::*;

   localparam int CW = 24;
   localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;
   localparam int LIMIT = 1000000;
   localparam int SETTLE = 400;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 last;
   } point_type;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 last;
   } vertex_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [CW-1:0] req_point_x;
   logic signed [CW-1:0] req_point_y;
   logic req_last_point;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [CW-1:0] rsp_vertex_x;
   logic signed [CW-1:0] rsp_vertex_y;
   logic rsp_last_of_run;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;

   thick_polyline_quad_expander_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_vertex_x(rsp_vertex_x),
      .rsp_vertex_y(rsp_vertex_y),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // shadow of the block configuration and polyline state
   bit [15:0] width_cfg = LINE_WIDTH_RESET;
   bit        closed_cfg = 1'b0;
   longint    first_x, first_y, prev_x, prev_y;
   int        pts_seen = 0;

   point_type  point_q[$];
   vertex_type vertex_q[$];
   int      errors = 0;
   int      vertex_count = 0;
   int      cycle = 0;
   bit      req_fire = 0;
   bit      no_idle = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   int      hold_cnt = 0;
   bit      hold_done = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 70) return $urandom_range(0, 2);
      if (r < 92) return $urandom_range(3, 6);
      return $urandom_range(10, 25);
   endfunction

   function automatic longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // half-width offset along one axis, rounded half up
   function automatic longint half_offset(bit [63:0] mag, bit neg, bit [63:0] len);
      bit [63:0] num, den, q;
      num = mag * width_cfg;
      den = len << 1;
      q = (num + den / 2) / den;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic void push_vertex(longint x, longint y);
      vertex_type v;
      v.x = clamp(x);
      v.y = clamp(y);
      v.last = 1'b0;
      vertex_q = {vertex_q, v};
   endfunction

   // six vertices of one square-capped quad, nothing for a zero-length segment
   function automatic int quad_vertices(longint x0, longint y0, longint x1, longint y1);
      longint dx, dy, ox, oy;
      bit [63:0] ax, ay, m, len;
      dx = x1 - x0;
      dy = y1 - y0;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax == 0 && ay == 0) return 0;
      m = ax > ay ? ax : ay;
      while (m < (64'd1 << 30)) begin
         ax = ax << 1; ay = ay << 1; m = m << 1;
      end
      while (m >= (64'd1 << 31)) begin
         ax = ax >> 1; ay = ay >> 1; m = m >> 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      ox = half_offset(ax, dx < 0, len);
      oy = half_offset(ay, dy < 0, len);
      push_vertex(x0 - ox + oy, y0 - oy - ox);
      push_vertex(x0 - ox - oy, y0 - oy + ox);
      push_vertex(x1 + ox - oy, y1 + oy + ox);
      push_vertex(x0 - ox + oy, y0 - oy - ox);
      push_vertex(x1 + ox - oy, y1 + oy + ox);
      push_vertex(x1 + ox + oy, y1 + oy - ox);
      return 6;
   endfunction

   // expected vertices for one accepted point
   function automatic void predict_point(longint x, longint y, bit last);
      int k;
      k = 0;
      if (pts_seen == 0) begin
         first_x = x;
         first_y = y;
      end else begin
         k += quad_vertices(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      if (pts_seen < 2) pts_seen++;
      if (last) begin
         if (closed_cfg && pts_seen >= 2) k += quad_vertices(x, y, first_x, first_y);
         pts_seen = 0;
      end
      if (k > 0) vertex_q[vertex_q.size() - 1].last = 1'b1;
   endfunction

   // point driver
   always @(negedge clock) begin
      point_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
         p = point_q.pop_front();
         req_point_x <= p.x;
         req_point_y <= p.y;
         req_last_point <= p.last;
         req_valid <= 1'b1;
         send_gap = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // vertex receiver, with one long hold-off once traffic is flowing
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && vertex_count >= 300) begin
         hold_done = 1;
         hold_cnt = 1500;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_gap = pick_gap();
      end
   end

   // accepted points feed the predictor, accepted vertices are checked
   always @(posedge clock) begin
      vertex_type e;
      cycle++;
      req_fire = req_valid && req_ready && !reset;
      if (req_fire) predict_point(req_point_x, req_point_y, req_last_point);
      if (rsp_valid && rsp_ready && !reset) begin
         vertex_count++;
         if (vertex_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected vertex x=%0d y=%0d last=%0b",
                        rsp_vertex_x, rsp_vertex_y, rsp_last_of_run);
         end else begin
            e = vertex_q.pop_front();
            if (e.x !== rsp_vertex_x || e.y !== rsp_vertex_y || e.last !== rsp_last_of_run) begin
               errors++;
               if (errors <= 10)
                  $display("vertex mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           e.x, e.y, e.last, rsp_vertex_x, rsp_vertex_y, rsp_last_of_run);
            end
         end
      end
      if (cycle > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic add_point(longint x, longint y, bit last);
      point_type p;
      p.x = x;
      p.y = y;
      p.last = last;
      point_q = {point_q, p};
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (point_q.size() != 0 || req_valid || vertex_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_LINE_WIDTH) width_cfg = data;
      else if (idx == CSR_CLOSED_LOOP) closed_cfg = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic longint rand_coord(longint base);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return longint'($signed(24'($urandom())));
      if (r == 1) return $urandom_range(0, 1) ? CMAX : CMIN;
      if (r == 2) return base;
      if (r < 6) return longint'($signed(24'(base + $signed($urandom_range(0, 8191)) - 4096)));
      return longint'($signed(24'(base + $signed($urandom_range(0, 524287)) - 262144)));
   endfunction

   // random polylines, mostly short, occasionally a repeated point
   task automatic add_polylines(int count);
      int n, i;
      longint x, y;
      x = longint'($signed(24'($urandom())));
      y = longint'($signed(24'($urandom())));
      while (count > 0) begin
         n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 7);
         if (n > count) n = count;
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) begin
               add_point(x, y, i == n - 1);
            end else if ($urandom_range(0, 1)) begin
               x = rand_coord(x);
               add_point(x, y, i == n - 1);
            end else begin
               x = rand_coord(x);
               y = rand_coord(y);
               add_point(x, y, i == n - 1);
            end
         end
         count -= n;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      req_last_point = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_LINE_WIDTH;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (SETTLE) @(posedge clock);

      // directed: lone point, plain segment, zero length, saturation
      add_point(0, 0, 1);
      add_point(0, 0, 0);
      add_point(2560, 0, 1);
      add_point(100, 100, 0);
      add_point(100, 100, 0);
      add_point(356, 100, 1);
      add_point(CMIN, CMIN, 0);
      add_point(CMAX, CMAX, 1);
      add_point(CMAX, CMIN, 0);
      add_point(CMIN, CMAX, 1);
      wait_idle();

      // directed: closed mode, two points, lone point, closing back on itself
      csr_write(CSR_CLOSED_LOOP, 16'd1);
      add_point(0, 0, 0);
      add_point(0, 512, 1);
      add_point(5, 5, 1);
      add_point(0, 0, 0);
      add_point(256, 0, 0);
      add_point(0, 0, 1);
      wait_idle();

      // directed: zero and full width
      csr_write(CSR_LINE_WIDTH, 16'd0);
      add_point(0, 0, 0);
      add_point(300, -700, 1);
      wait_idle();
      csr_write(CSR_LINE_WIDTH, 16'hFFFF);
      add_point(-1000, 2000, 0);
      add_point(CMAX, CMIN, 1);
      wait_idle();

      // random phases over several settings
      no_idle = 1;
      add_polylines(110);
      wait_idle();
      no_idle = 0;
      csr_write(CSR_CLOSED_LOOP, 16'd0);
      csr_write(CSR_LINE_WIDTH, 16'd0);
      add_polylines(110);
      wait_idle();
      csr_write(CSR_CLOSED_LOOP, 16'd1);
      csr_write(CSR_LINE_WIDTH, 16'($urandom()));
      add_polylines(110);
      wait_idle();
      csr_write(CSR_CLOSED_LOOP, 16'($urandom_range(0, 1)));
      csr_write(CSR_LINE_WIDTH, 16'($urandom_range(1, 4096)));
      add_polylines(110);
      wait_idle();

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
